[hw/rtl/npc_pkg.sv]
// ----------------------------------------------------------------------------
// npc_pkg: shared types, constants and functions of the near-plane clipper
// Holds the vertex and clip plan types, the fixed datapath widths, the
// saturation helper and the per-code clip plan table.
// ----------------------------------------------------------------------------
package npc_pkg;

  // Default parameter values.
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Field widths of the words on the ports.
  localparam int unsigned COORD_W = 32;
  localparam int unsigned NEAR_W  = 31;
  localparam int unsigned FACES_W = 16;

  // Datapath widths: multiplier operands, product, divider, saturation input.
  localparam int unsigned OPW    = 34;
  localparam int unsigned PROD_W = 2 * OPW;
  localparam int unsigned DVD_W  = 64;
  localparam int unsigned DVS_W  = OPW;
  localparam int unsigned SAT_W  = 72;

  // Vertex indices inside a triangle.
  localparam logic [1:0] VI0 = 2'd0;
  localparam logic [1:0] VI1 = 2'd1;
  localparam logic [1:0] VI2 = 2'd2;

  // Where a corner of an emitted triangle comes from.
  typedef enum logic [2:0] {
    SRC_V0,
    SRC_V1,
    SRC_V2,
    SRC_C0,
    SRC_C1,
    SRC_CV
  } src_e;

  typedef struct packed {
    src_e a;
    src_e b;
    src_e c;
  } tri_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  // How one inside/outside code is handled.
  typedef struct packed {
    logic [1:0] n_tri;
    logic       clipped;
    tri_t       t0;
    tri_t       t1;
    logic [1:0] e0p;
    logic [1:0] e0q;
    logic [1:0] e1p;
    logic [1:0] e1q;
  } plan_t;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } div_stat_t;

  // Clamp a wide signed value into signed 32 bit.
  function automatic logic signed [COORD_W-1:0] sat32(logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7FFF_FFFF);
    lo = -hi - 1;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return -32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

  // Edges to cut and triangles to emit for each code (vertex 0 is the top bit).
  function automatic plan_t clip_plan(logic [2:0] code);
    plan_t p;
    p = '0;
    unique case (code)
      3'd7: begin
        p.n_tri = 2'd1;
        p.t0    = '{SRC_V0, SRC_V1, SRC_V2};
      end
      3'd6: begin
        p.n_tri = 2'd2; p.clipped = 1'b1;
        p.e0p = VI1; p.e0q = VI2; p.e1p = VI2; p.e1q = VI0;
        p.t0  = '{SRC_V0, SRC_V1, SRC_C0};
        p.t1  = '{SRC_C0, SRC_C1, SRC_V0};
      end
      3'd5: begin
        p.n_tri = 2'd2; p.clipped = 1'b1;
        p.e0p = VI0; p.e0q = VI1; p.e1p = VI1; p.e1q = VI2;
        p.t0  = '{SRC_V0, SRC_C0, SRC_C1};
        p.t1  = '{SRC_C1, SRC_V2, SRC_V0};
      end
      3'd4: begin
        p.n_tri = 2'd1; p.clipped = 1'b1;
        p.e0p = VI0; p.e0q = VI1; p.e1p = VI2; p.e1q = VI0;
        p.t0  = '{SRC_V0, SRC_C0, SRC_C1};
      end
      3'd3: begin
        p.n_tri = 2'd2; p.clipped = 1'b1;
        p.e0p = VI0; p.e0q = VI1; p.e1p = VI2; p.e1q = VI0;
        p.t0  = '{SRC_C0, SRC_V1, SRC_V2};
        p.t1  = '{SRC_V2, SRC_C1, SRC_C0};
      end
      3'd2: begin
        p.n_tri = 2'd1; p.clipped = 1'b1;
        p.e0p = VI0; p.e0q = VI1; p.e1p = VI1; p.e1q = VI2;
        p.t0  = '{SRC_C0, SRC_V1, SRC_C1};
      end
      3'd1: begin
        p.n_tri = 2'd1; p.clipped = 1'b1;
        p.e0p = VI1; p.e0q = VI2; p.e1p = VI2; p.e1q = VI0;
        p.t0  = '{SRC_C0, SRC_V2, SRC_C1};
      end
      default: begin
        p.n_tri = 2'd0;
      end
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/npc_div.sv]
// ----------------------------------------------------------------------------
// npc_div: shared iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero. Flags a zero divisor for the caller to override.
// ----------------------------------------------------------------------------
module npc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [npc_pkg::DVD_W-1:0]  dividend_i,
  input  logic signed [npc_pkg::DVS_W-1:0]  divisor_i,
  output logic signed [npc_pkg::DVD_W-1:0]  quot_o,
  output npc_pkg::div_stat_t                stat_o
);
  import npc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic             busy_q;
  logic             done_q;
  logic             zero_q;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try the divisor.
  always_comb begin
    shifted = {rem_q, dvd_q[DVD_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dvd_q  <= dividend_i[DVD_W-1] ? DVD_W'(-dividend_i) : DVD_W'(dividend_i);
        dvs_q  <= divisor_i[DVS_W-1] ? DVS_W'(-divisor_i) : DVS_W'(divisor_i);
        rem_q  <= '0;
        cnt_q  <= CNT_W'(DVD_W - 1);
        neg_q  <= dividend_i[DVD_W-1] ^ divisor_i[DVS_W-1];
        zero_q <= (divisor_i == '0);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        dvd_q <= {dvd_q[DVD_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The dividend register holds the quotient once the last step is done.
  assign quot_o      = neg_q ? $signed(-dvd_q) : $signed(dvd_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.zero = zero_q;

endmodule

[hw/rtl/npc_mul.sv]
// ----------------------------------------------------------------------------
// npc_mul: shared fixed-point multiplier
// Two-stage signed multiply followed by a scale down by the fraction width,
// rounding toward zero.
// ----------------------------------------------------------------------------
module npc_mul #(
  parameter int unsigned FRAC_BITS = npc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [npc_pkg::OPW-1:0]     a_i,
  input  logic signed [npc_pkg::OPW-1:0]     b_i,
  output logic signed [npc_pkg::PROD_W-1:0]  res_o,
  output logic                               done_o
);
  import npc_pkg::*;

  localparam logic [PROD_W-1:0] BIAS = {{(PROD_W - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] res_q;
  logic signed [PROD_W-1:0] biased;
  logic                     stage1_q;
  logic                     done_q;

  // Negative products get a bias so the shift truncates toward zero.
  always_comb begin
    biased = prod_q[PROD_W-1] ? (prod_q + $signed(BIAS)) : prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q   <= '0;
      res_q    <= '0;
      stage1_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      stage1_q <= start_i;
      done_q   <= stage1_q;
      if (start_i) begin
        prod_q <= a_i * b_i;
      end
      if (stage1_q) begin
        res_q <= biased >>> FRAC_BITS;
      end
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

[hw/rtl/near_plane_clip_volume_triangles.sv]
// ----------------------------------------------------------------------------
// near_plane_clip_volume_triangles: near-plane triangle clipper
// Takes one triangle a word and emits zero to four words: the passed or
// clipped triangles, a cover triangle from the list's first clip point and
// an end-of-list marker.
// ----------------------------------------------------------------------------
// A triangle word is taken only while the block is idle. Its three depth
// reciprocals are computed first, then every cut edge needs one more divide
// for the edge parameter, one for the new depth and nine multiplies. All
// divides run on one shared divider that produces one quotient bit a cycle,
// and the multiplies use one shared two-stage multiplier. Then the result
// words are handed out slot by slot as the output register frees. Results
// sit in an output register, so a new triangle is taken while the last
// result still waits to be read. The near threshold is written through its
// own channel, which is always ready.
module near_plane_clip_volume_triangles #(
  parameter int unsigned FRAC_BITS  = npc_pkg::FRAC_BITS_DEF,
  parameter int unsigned COUNT_BITS = npc_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Threshold write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [npc_pkg::NEAR_W-1:0]           cfg_near_z_i,
  // Triangle input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [npc_pkg::COORD_W-1:0]   v0_x_i,
  input  logic signed [npc_pkg::COORD_W-1:0]   v0_y_i,
  input  logic signed [npc_pkg::COORD_W-1:0]   v0_z_i,
  input  logic signed [npc_pkg::COORD_W-1:0]   v1_x_i,
  input  logic signed [npc_pkg::COORD_W-1:0]   v1_y_i,
  input  logic signed [npc_pkg::COORD_W-1:0]   v1_z_i,
  input  logic signed [npc_pkg::COORD_W-1:0]   v2_x_i,
  input  logic signed [npc_pkg::COORD_W-1:0]   v2_y_i,
  input  logic signed [npc_pkg::COORD_W-1:0]   v2_z_i,
  input  logic                                 last_triangle_i,
  // Result output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [npc_pkg::COORD_W-1:0]   out0_x_o,
  output logic signed [npc_pkg::COORD_W-1:0]   out0_y_o,
  output logic signed [npc_pkg::COORD_W-1:0]   out0_z_o,
  output logic signed [npc_pkg::COORD_W-1:0]   out1_x_o,
  output logic signed [npc_pkg::COORD_W-1:0]   out1_y_o,
  output logic signed [npc_pkg::COORD_W-1:0]   out1_z_o,
  output logic signed [npc_pkg::COORD_W-1:0]   out2_x_o,
  output logic signed [npc_pkg::COORD_W-1:0]   out2_y_o,
  output logic signed [npc_pkg::COORD_W-1:0]   out2_z_o,
  output logic                                 end_of_list_o,
  output logic                                 last_of_run_o,
  output logic [npc_pkg::FACES_W-1:0]          faces_so_far_o
);
  import npc_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  // Work steps of one triangle.
  localparam logic [3:0] SP_R0   = 4'd0;
  localparam logic [3:0] SP_R1   = 4'd1;
  localparam logic [3:0] SP_R2   = 4'd2;
  localparam logic [3:0] SP_PLAN = 4'd3;
  localparam logic [3:0] SP_LOAD = 4'd4;
  localparam logic [3:0] SP_T    = 4'd5;
  localparam logic [3:0] SP_M    = 4'd6;
  localparam logic [3:0] SP_RZ   = 4'd7;
  localparam logic [3:0] SP_AX   = 4'd8;
  localparam logic [3:0] SP_BX   = 4'd9;
  localparam logic [3:0] SP_HX   = 4'd10;
  localparam logic [3:0] SP_XX   = 4'd11;
  localparam logic [3:0] SP_AY   = 4'd12;
  localparam logic [3:0] SP_BY   = 4'd13;
  localparam logic [3:0] SP_HY   = 4'd14;
  localparam logic [3:0] SP_XY   = 4'd15;

  // Result slots in output order.
  localparam logic [2:0] SL_TRI0  = 3'd0;
  localparam logic [2:0] SL_TRI1  = 3'd1;
  localparam logic [2:0] SL_COVER = 3'd2;
  localparam logic [2:0] SL_EOL   = 3'd3;
  localparam logic [2:0] SL_DONE  = 3'd4;

  localparam logic [DVD_W-1:0]   RCP_NUM   = DVD_W'(1) << (2 * FRAC_BITS);
  localparam logic [DVD_W-1:0]   ONE_DVD   = DVD_W'(1) << FRAC_BITS;
  localparam logic [NEAR_W-1:0]  NEAR_RST  = NEAR_W'(1) << FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_CAP = {COUNT_BITS{1'b1}};
  localparam logic signed [COORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;

  // Pick one of three vertices.
  function automatic vtx_t sel3(logic [1:0] idx, vtx_t a, vtx_t b, vtx_t c);
    unique case (idx)
      VI0:     return a;
      VI1:     return b;
      default: return c;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] selw(logic [1:0] idx,
      logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b,
      logic signed [COORD_W-1:0] c);
    unique case (idx)
      VI0:     return a;
      VI1:     return b;
      default: return c;
    endcase
  endfunction

  // Corner source of an emitted triangle.
  function automatic vtx_t pick(src_e s, vtx_t v0, vtx_t v1, vtx_t v2,
      vtx_t c0, vtx_t c1, vtx_t cv);
    unique case (s)
      SRC_V0:  return v0;
      SRC_V1:  return v1;
      SRC_V2:  return v2;
      SRC_C0:  return c0;
      SRC_C1:  return c1;
      default: return cv;
    endcase
  endfunction

  // Face count as shown on the port, saturated to its width.
  function automatic logic [FACES_W-1:0] shown(logic [COUNT_BITS-1:0] n);
    logic [32:0] w;
    w = 33'(n);
    return (w > 33'h0_FFFF) ? {FACES_W{1'b1}} : w[FACES_W-1:0];
  endfunction

  // Control state.
  logic [1:0]  state_q;
  logic [3:0]  step_q;
  logic [2:0]  slot_q;
  logic        edge_q;
  logic        last_q;
  plan_t       plan_q;
  logic        out_valid_q;

  // List state.
  vtx_t                   cover_q;
  logic                   cover_valid_q;
  logic [COUNT_BITS-1:0]  face_total_q;
  logic [NEAR_W-1:0]      near_q;

  // Datapath registers.
  vtx_t                       v0_q, v1_q, v2_q, c0_q, c1_q;
  logic signed [COORD_W-1:0]  w0_q, w1_q, w2_q;
  logic signed [COORD_W-1:0]  pw_q, qw_q, px_q, py_q, qx_q, qy_q;
  logic signed [OPW-1:0]      t_q, m_q;
  logic signed [COORD_W-1:0]  rz_q, a_q, b_q, h_q;

  // Output word.
  vtx_t               oa_q, ob_q, oc_q;
  logic               eol_q, lor_q;
  logic [FACES_W-1:0] faces_q;

  // Shared units.
  logic                     div_start, mul_start, mul_done;
  logic signed [DVD_W-1:0]  div_dvd, div_quot;
  logic signed [DVS_W-1:0]  div_dvs;
  logic signed [OPW-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_res;
  div_stat_t                div_stat;

  npc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  npc_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res),
    .done_o  (mul_done)
  );

  // Coordinate of the edge end points for the x or y pass.
  logic                      y_pass;
  logic signed [COORD_W-1:0] pc, qc;
  logic signed [OPW-1:0]     tdiff;
  vtx_t                      zsrc;

  always_comb begin
    y_pass = (step_q >= SP_AY);
    pc     = y_pass ? py_q : px_q;
    qc     = y_pass ? qy_q : qx_q;
    tdiff  = OPW'(pw_q) - OPW'({1'b0, near_q});
    zsrc   = sel3(step_q[1:0], v0_q, v1_q, v2_q);
  end

  // Operand selection and start of the shared units.
  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    mul_a     = '0;
    mul_b     = '0;
    if (state_q == ST_ISSUE) begin
      unique case (step_q)
        SP_R0, SP_R1, SP_R2: begin
          div_start = 1'b1;
          div_dvd   = $signed(RCP_NUM);
          div_dvs   = DVS_W'(zsrc.z);
        end
        SP_T: begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(tdiff) <<< FRAC_BITS;
          div_dvs   = OPW'(pw_q) - OPW'(qw_q);
        end
        SP_M: begin
          mul_start = 1'b1;
          mul_a     = OPW'(qw_q) - OPW'(pw_q);
          mul_b     = t_q;
        end
        SP_RZ: begin
          div_start = 1'b1;
          div_dvd   = $signed(RCP_NUM);
          div_dvs   = OPW'(pw_q) + m_q;
        end
        SP_AX, SP_AY: begin
          mul_start = 1'b1;
          mul_a     = OPW'(pc);
          mul_b     = OPW'(pw_q);
        end
        SP_BX, SP_BY: begin
          mul_start = 1'b1;
          mul_a     = OPW'(qc);
          mul_b     = OPW'(qw_q);
        end
        SP_HX, SP_HY: begin
          mul_start = 1'b1;
          mul_a     = OPW'(b_q) - OPW'(a_q);
          mul_b     = t_q;
        end
        SP_XX, SP_XY: begin
          mul_start = 1'b1;
          mul_a     = OPW'(h_q);
          mul_b     = OPW'(rz_q);
        end
        default: ;
      endcase
    end
  end

  // Write-back values of the shared units.
  logic signed [COORD_W-1:0] rcp_val, mul_sat, h_val;
  logic signed [OPW-1:0]     t_val;

  always_comb begin
    rcp_val = div_stat.zero ? W_MAX : sat32(SAT_W'(div_quot));
    mul_sat = sat32(SAT_W'(mul_res));
    h_val   = sat32(SAT_W'(a_q) + SAT_W'(mul_res));
    if (div_stat.zero || div_quot[DVD_W-1]) begin
      t_val = '0;
    end else if ($unsigned(div_quot) > ONE_DVD) begin
      t_val = OPW'(ONE_DVD);
    end else begin
      t_val = OPW'(div_quot);
    end
  end

  // Inside test, edge end points and result bookkeeping.
  logic [2:0]            ins;
  plan_t                 plan_d;
  logic [1:0]            ep, eq;
  vtx_t                  pv, qv;
  logic [3:0]            pres;
  logic                  later;
  logic                  out_free;
  logic                  out_load;
  tri_t                  cur_tri;
  logic [COUNT_BITS-1:0] total_inc;

  always_comb begin
    ins[2]    = (w0_q >= $signed({1'b0, near_q}));
    ins[1]    = (w1_q >= $signed({1'b0, near_q}));
    ins[0]    = (w2_q >= $signed({1'b0, near_q}));
    plan_d    = clip_plan(ins);
    ep        = edge_q ? plan_q.e1p : plan_q.e0p;
    eq        = edge_q ? plan_q.e1q : plan_q.e0q;
    pv        = sel3(ep, v0_q, v1_q, v2_q);
    qv        = sel3(eq, v0_q, v1_q, v2_q);
    pres[0]   = (plan_q.n_tri != 2'd0);
    pres[1]   = (plan_q.n_tri == 2'd2);
    pres[2]   = plan_q.clipped && cover_valid_q;
    pres[3]   = last_q;
    unique case (slot_q)
      SL_TRI0:  later = pres[1] || pres[2] || pres[3];
      SL_TRI1:  later = pres[2] || pres[3];
      SL_COVER: later = pres[3];
      default:  later = 1'b0;
    endcase
    out_free  = !out_valid_q || out_ready_i;
    out_load  = (state_q == ST_EMIT) && (slot_q != SL_DONE) && pres[slot_q[1:0]] &&
                out_free;
    unique case (slot_q)
      SL_TRI0:  cur_tri = plan_q.t0;
      SL_TRI1:  cur_tri = plan_q.t1;
      default:  cur_tri = '{SRC_CV, SRC_C0, SRC_C1};
    endcase
    total_inc = (face_total_q == CNT_CAP) ? face_total_q : face_total_q + 1'b1;
  end

  // Sequencer, datapath registers and output word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= SP_R0;
      slot_q        <= SL_TRI0;
      edge_q        <= 1'b0;
      last_q        <= 1'b0;
      plan_q        <= '0;
      out_valid_q   <= 1'b0;
      cover_q       <= '0;
      cover_valid_q <= 1'b0;
      face_total_q  <= '0;
      near_q        <= NEAR_RST;
      v0_q <= '0; v1_q <= '0; v2_q <= '0; c0_q <= '0; c1_q <= '0;
      w0_q <= '0; w1_q <= '0; w2_q <= '0;
      pw_q <= '0; qw_q <= '0; px_q <= '0; py_q <= '0; qx_q <= '0; qy_q <= '0;
      t_q  <= '0; m_q <= '0; rz_q <= '0; a_q <= '0; b_q <= '0; h_q <= '0;
      oa_q <= '0; ob_q <= '0; oc_q <= '0;
      eol_q <= 1'b0; lor_q <= 1'b0; faces_q <= '0;
    end else begin
      // Threshold write.
      if (cfg_valid_i) begin
        near_q <= cfg_near_z_i;
      end

      // The output word leaves when taken, unless the next one replaces it.
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            v0_q    <= '{v0_x_i, v0_y_i, v0_z_i};
            v1_q    <= '{v1_x_i, v1_y_i, v1_z_i};
            v2_q    <= '{v2_x_i, v2_y_i, v2_z_i};
            last_q  <= last_triangle_i;
            step_q  <= SP_R0;
            edge_q  <= 1'b0;
            state_q <= ST_ISSUE;
          end
        end

        ST_ISSUE: begin
          priority if (step_q == SP_PLAN) begin
            plan_q <= plan_d;
            slot_q <= SL_TRI0;
            if (plan_d.clipped) begin
              step_q <= SP_LOAD;
            end else begin
              state_q <= ST_EMIT;
            end
          end else if (step_q == SP_LOAD) begin
            pw_q   <= selw(ep, w0_q, w1_q, w2_q);
            qw_q   <= selw(eq, w0_q, w1_q, w2_q);
            px_q   <= pv.x;
            py_q   <= pv.y;
            qx_q   <= qv.x;
            qy_q   <= qv.y;
            step_q <= SP_T;
          end else begin
            state_q <= ST_WAIT;
          end
        end

        ST_WAIT: begin
          if (div_stat.done || mul_done) begin
            unique case (step_q)
              SP_R0: w0_q <= rcp_val;
              SP_R1: w1_q <= rcp_val;
              SP_R2: w2_q <= rcp_val;
              SP_T:  t_q  <= t_val;
              SP_M:  m_q  <= OPW'(mul_res);
              SP_RZ: begin
                rz_q <= rcp_val;
                if (edge_q) c1_q.z <= rcp_val;
                else        c0_q.z <= rcp_val;
              end
              SP_AX, SP_AY: a_q <= mul_sat;
              SP_BX, SP_BY: b_q <= mul_sat;
              SP_HX, SP_HY: h_q <= h_val;
              SP_XX: begin
                if (edge_q) c1_q.x <= mul_sat;
                else        c0_q.x <= mul_sat;
              end
              SP_XY: begin
                if (edge_q) c1_q.y <= mul_sat;
                else        c0_q.y <= mul_sat;
              end
              default: ;
            endcase
            if (step_q == SP_XY) begin
              if (!edge_q) begin
                edge_q  <= 1'b1;
                step_q  <= SP_LOAD;
                state_q <= ST_ISSUE;
              end else begin
                state_q <= ST_EMIT;
              end
            end else begin
              step_q  <= step_q + 1'b1;
              state_q <= ST_ISSUE;
            end
          end
        end

        default: begin
          // Hand out the result words slot by slot.
          if (slot_q == SL_DONE) begin
            if (last_q) begin
              cover_q       <= '0;
              cover_valid_q <= 1'b0;
              face_total_q  <= '0;
            end else if (plan_q.clipped && !cover_valid_q) begin
              cover_q       <= c0_q;
              cover_valid_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end else if (!pres[slot_q[1:0]]) begin
            slot_q <= slot_q + 1'b1;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            lor_q       <= !later;
            if (slot_q == SL_EOL) begin
              oa_q    <= '0;
              ob_q    <= '0;
              oc_q    <= '0;
              eol_q   <= 1'b1;
              faces_q <= shown(face_total_q);
            end else begin
              oa_q         <= pick(cur_tri.a, v0_q, v1_q, v2_q, c0_q, c1_q, cover_q);
              ob_q         <= pick(cur_tri.b, v0_q, v1_q, v2_q, c0_q, c1_q, cover_q);
              oc_q         <= pick(cur_tri.c, v0_q, v1_q, v2_q, c0_q, c1_q, cover_q);
              eol_q        <= 1'b0;
              faces_q      <= shown(total_inc);
              face_total_q <= total_inc;
            end
            slot_q <= slot_q + 1'b1;
          end
        end
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out0_x_o       = oa_q.x;
  assign out0_y_o       = oa_q.y;
  assign out0_z_o       = oa_q.z;
  assign out1_x_o       = ob_q.x;
  assign out1_y_o       = ob_q.y;
  assign out1_z_o       = ob_q.z;
  assign out2_x_o       = oc_q.x;
  assign out2_y_o       = oc_q.y;
  assign out2_z_o       = oc_q.z;
  assign end_of_list_o  = eol_q;
  assign last_of_run_o  = lor_q;
  assign faces_so_far_o = faces_q;

  // A unit result only arrives while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.done || mul_done) |-> (state_q == ST_WAIT))
    else $error("unit result outside of wait state");

  // The two shared units never work at the same time.
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_stat.busy && (mul_start || mul_done)))
    else $error("divider and multiplier active together");

  // The end-of-list word is always the final word of its triangle.
  a_eol_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_list_o) |-> last_of_run_o)
    else $error("end-of-list word not marked last");

  // A taken triangle makes the block busy.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after a triangle was taken");

endmodule
